// ----- hw/rtl/rfc8_pkg.sv -----
`timescale 1ns / 1ps

package rfc8_pkg;

    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [7:0]  CRC_MSB       = 8'h80;
    localparam logic [7:0]  CRC_INIT      = 8'h00;
    localparam logic [7:0]  CODE_READ_OUT = 8'hC3;
    localparam logic [15:0] STATE_NONE    = 16'h0000;

    localparam int          POS_W         = 9;
    localparam logic [8:0]  POS_LEN       = 9'd2;
    localparam logic [8:0]  POS_CODE      = 9'd3;
    localparam logic [8:0]  POS_HIGH      = 9'd4;
    localparam logic [8:0]  POS_LOW       = 9'd5;

    // Bitwise CRC-8 update, MSB first, eight shift steps on an 8-bit value.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/reply_frame_crc8_checker_top.sv -----
`timescale 1ns / 1ps

// Reply frame CRC-8 checker.
// Input channel: one raw reply byte per item (i_rx_byte) with i_frame_start
// high on the first byte of a frame. Byte 2 is the payload length L, byte 3
// the function code, and byte 3+L the received check byte.
// Output channel: one item per frame, issued for its check byte, carrying
// crc_ok, both CRC values, the function code, and for code 0xC3 with a good
// CRC the 16-bit output state from bytes 4 and 5.
// Throughput is one byte per cycle unless the output stalls: the frame state
// and the unrolled CRC update sit between the accepted byte and the output
// register. A result appears in the cycle after its check byte is accepted.
// Bytes outside a frame, and trailing bytes after the check byte, give no
// item. A new start abandons an unfinished frame.
// Synchronous reset clears the frame state to idle and empties the output.
// While a result waits in the output register and the receiver stalls, the
// input is stalled as well, so no item is lost. With no result waiting, or
// with the receiver taking it, the input keeps taking one byte per cycle.
module reply_frame_crc8_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_crc_ok,
    output logic [7:0]  o_computed_crc,
    output logic [7:0]  o_received_crc,
    output logic [7:0]  o_function_code,
    output logic [15:0] o_output_state,
    output logic        o_state_valid
);

    logic [rfc8_pkg::POS_W-1:0] r_byte_pos, n_byte_pos;
    logic [7:0]  r_crc, n_crc;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic        r_frame_active, n_frame_active;

    logic        r_out_valid;
    logic        r_crc_ok;
    logic [7:0]  r_computed_crc;
    logic [7:0]  r_received_crc;
    logic [7:0]  r_function_code;
    logic [15:0] r_output_state;
    logic        r_state_valid;

    logic        in_accept;
    logic        check_hit;
    logic        ok;
    logic        valid;
    logic [rfc8_pkg::POS_W-1:0] e_pos;
    logic [7:0]  e_crc, e_len, e_code, e_high, e_low;
    logic        e_active;
    logic [rfc8_pkg::POS_W-1:0] check_pos;

    // A held result blocks only when its receiver stalls.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        // A start byte sees freshly cleared frame state.
        if (i_frame_start) begin
            e_pos    = '0;
            e_crc    = rfc8_pkg::CRC_INIT;
            e_len    = 8'h00;
            e_code   = 8'h00;
            e_high   = 8'h00;
            e_low    = 8'h00;
            e_active = 1'b1;
        end else begin
            e_pos    = r_byte_pos;
            e_crc    = r_crc;
            e_len    = r_len;
            e_code   = r_code;
            e_high   = r_high;
            e_low    = r_low;
            e_active = r_frame_active;
        end

        if (e_pos == rfc8_pkg::POS_LEN)  e_len  = i_rx_byte;
        if (e_pos == rfc8_pkg::POS_CODE) e_code = i_rx_byte;
        if (e_pos == rfc8_pkg::POS_HIGH) e_high = i_rx_byte;
        if (e_pos == rfc8_pkg::POS_LOW)  e_low  = i_rx_byte;

        check_pos = rfc8_pkg::POS_CODE + {1'b0, e_len};
        check_hit = e_active && (e_pos >= rfc8_pkg::POS_CODE) && (e_pos == check_pos);
        ok        = (i_rx_byte == e_crc);
        valid     = ok && (e_code == rfc8_pkg::CODE_READ_OUT);

        n_byte_pos     = r_byte_pos;
        n_crc          = r_crc;
        n_len          = r_len;
        n_code         = r_code;
        n_high         = r_high;
        n_low          = r_low;
        n_frame_active = r_frame_active;
        if (in_accept && e_active) begin
            n_len  = e_len;
            n_code = e_code;
            n_high = e_high;
            n_low  = e_low;
            if (check_hit) begin
                n_byte_pos     = e_pos;
                n_crc          = e_crc;
                n_frame_active = 1'b0;
            end else begin
                n_byte_pos     = e_pos + 9'd1;
                n_crc          = rfc8_pkg::crc8_update(e_crc, i_rx_byte);
                n_frame_active = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos     <= '0;
            r_crc          <= rfc8_pkg::CRC_INIT;
            r_len          <= 8'h00;
            r_code         <= 8'h00;
            r_high         <= 8'h00;
            r_low          <= 8'h00;
            r_frame_active <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_byte_pos     <= n_byte_pos;
            r_crc          <= n_crc;
            r_len          <= n_len;
            r_code         <= n_code;
            r_high         <= n_high;
            r_low          <= n_low;
            r_frame_active <= n_frame_active;
            if (in_accept && check_hit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && check_hit) begin
            r_crc_ok        <= ok;
            r_computed_crc  <= e_crc;
            r_received_crc  <= i_rx_byte;
            r_function_code <= e_code;
            r_output_state  <= valid ? {e_high, e_low} : rfc8_pkg::STATE_NONE;
            r_state_valid   <= valid;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_crc_ok        = r_crc_ok;
    assign o_computed_crc  = r_computed_crc;
    assign o_received_crc  = r_received_crc;
    assign o_function_code = r_function_code;
    assign o_output_state  = r_output_state;
    assign o_state_valid   = r_state_valid;

    a_state_needs_crc : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_state_valid) |-> (o_crc_ok
            && o_function_code == rfc8_pkg::CODE_READ_OUT))
        else $error("state_valid without a good CRC and read-out code");

    a_state_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_state_valid) |-> (o_output_state == rfc8_pkg::STATE_NONE))
        else $error("output_state not cleared for an invalid frame");

    a_start_opens_frame : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_frame_start) |=> (r_frame_active && r_byte_pos == 9'd1))
        else $error("start byte did not open a frame");

    a_result_from_check : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && check_hit) |=> (o_out_valid && !r_frame_active))
        else $error("check byte did not close the frame with a result");

    a_crc_ok_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_crc_ok == (o_computed_crc == o_received_crc)))
        else $error("crc_ok does not match the CRC values");

endmodule
